>>> hdl/sfs_pkg.sv
package sfs_pkg;

   localparam int FRAME_W  = 10;
   localparam int TICK_W   = 20;
   localparam int ACC_W    = TICK_W + 1;
   localparam int Q16_W    = 17;
   localparam int COORD_W  = 27;
   localparam int DIVD_W   = ACC_W + 1;
   localparam int DIVR_W   = TICK_W;
   localparam int STEP_W   = 5;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;

   // divide lengths in bits of quotient
   localparam logic [STEP_W-1:0] TICK_STEPS  = STEP_W'(ACC_W);
   localparam logic [STEP_W-1:0] WRAP_STEPS  = STEP_W'(DIVD_W);
   localparam logic [STEP_W-1:0] SHEET_STEPS = STEP_W'(FRAME_W);

   // register indexes (byte address / 4)
   localparam logic [2:0] CSR_FRAME_COUNT     = 3'd0;
   localparam logic [2:0] CSR_FRAMES_PER_ROW  = 3'd1;
   localparam logic [2:0] CSR_FRAME_PERIOD    = 3'd2;
   localparam logic [2:0] CSR_LOOP_ENABLE     = 3'd3;
   localparam logic [2:0] CSR_X_STEP          = 3'd4;
   localparam logic [2:0] CSR_Y_STEP          = 3'd5;
   localparam logic [2:0] CSR_OVERRIDE_ENABLE = 3'd6;
   localparam logic [2:0] CSR_OVERRIDE_HEIGHT = 3'd7;

   localparam logic OP_ADVANCE   = 1'b0;
   localparam logic OP_SET_FRAME = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [TICK_W-1:0]  elapsed;
      logic [FRAME_W-1:0] frame_value;
   } req_payload_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [COORD_W-1:0] tex_x;
      logic [COORD_W-1:0] tex_y;
      logic [Q16_W-1:0]   tex_w;
      logic [Q16_W-1:0]   tex_h;
      logic               rejected;
   } rsp_payload_type;

   typedef struct packed {
      logic               start;
      logic [DIVD_W-1:0]  dividend;
      logic [DIVR_W-1:0]  divisor;
      logic [STEP_W-1:0]  steps;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIVD_W-1:0]  quotient;
      logic [DIVR_W-1:0]  remainder;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK_GO,
      ST_TICK_WAIT,
      ST_WRAP_GO,
      ST_WRAP_WAIT,
      ST_SHEET_GO,
      ST_SHEET_WAIT,
      ST_MULT,
      ST_OUT
   } state_type;

endpackage

>>> hdl/sprite_frame_sequencer_core.sv
// Each item runs the tick division (advance only), the wrap division (only when
// the frame wraps), the sheet division, the multiply and the output state in turn.
// The next item is taken the cycle after its predecessor's result is registered;
// no new item is taken while one is in work or waits for the result side.
// The divisions run on the one-bit-per-cycle divider shared by the tick, wrap and
// sheet divisions (21, 22 and 10 steps). Synchronous reset restores the register
// defaults, clears frame and tick accumulator and drops any pending result.
module sprite_frame_sequencer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sfs_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sfs_pkg::rsp_payload_type      rsp_payload,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sfs_pkg::CSR_AW-1:0]    paddr,
   input  logic [sfs_pkg::CSR_DW-1:0]    pwdata,
   output logic [sfs_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);
   import sfs_pkg::*;

   logic [FRAME_W-1:0] frame_count_ff, frames_per_row_ff;
   logic [TICK_W-1:0]  frame_period_ff;
   logic               loop_enable_ff, override_enable_ff;
   logic [Q16_W-1:0]   x_step_ff, y_step_ff, override_height_ff;

   state_type          state_ff, state_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [DIVD_W-1:0]  wrap_ff, wrap_in;
   logic               rej_ff, rej_in;
   logic [FRAME_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [COORD_W-1:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               csr_write;
   logic [2:0]         csr_index;
   logic [DIVD_W-1:0]  next_sum;
   logic [FRAME_W-1:0] fpr_eff;
   logic [TICK_W-1:0]  period_eff;
   logic [Q16_W-1:0]   height_eff;

   sfs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign csr_write  = psel & penable & pwrite;
   assign csr_index  = paddr[CSR_AW-1:2];
   assign pready     = 1'b1;
   assign fpr_eff    = (frames_per_row_ff == '0) ? FRAME_W'(1) : frames_per_row_ff;
   assign period_eff = (frame_period_ff == '0) ? TICK_W'(1) : frame_period_ff;
   assign height_eff = (override_height_ff > ONE_Q16) ? ONE_Q16 : override_height_ff;
   assign next_sum   = DIVD_W'(frame_ff) + DIVD_W'(div_rsp.quotient[ACC_W-1:0]);

   always_comb begin
      case (csr_index)
         CSR_FRAME_COUNT:     prdata = CSR_DW'(frame_count_ff);
         CSR_FRAMES_PER_ROW:  prdata = CSR_DW'(frames_per_row_ff);
         CSR_FRAME_PERIOD:    prdata = CSR_DW'(frame_period_ff);
         CSR_LOOP_ENABLE:     prdata = CSR_DW'(loop_enable_ff);
         CSR_X_STEP:          prdata = CSR_DW'(x_step_ff);
         CSR_Y_STEP:          prdata = CSR_DW'(y_step_ff);
         CSR_OVERRIDE_ENABLE: prdata = CSR_DW'(override_enable_ff);
         CSR_OVERRIDE_HEIGHT: prdata = CSR_DW'(override_height_ff);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff     <= FRAME_W'(1);
         frames_per_row_ff  <= FRAME_W'(1);
         frame_period_ff    <= TICK_W'(1);
         loop_enable_ff     <= 1'b1;
         x_step_ff          <= ONE_Q16;
         y_step_ff          <= ONE_Q16;
         override_enable_ff <= 1'b0;
         override_height_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FRAME_COUNT:     frame_count_ff     <= pwdata[FRAME_W-1:0];
            CSR_FRAMES_PER_ROW:  frames_per_row_ff  <= pwdata[FRAME_W-1:0];
            CSR_FRAME_PERIOD:    frame_period_ff    <= pwdata[TICK_W-1:0];
            CSR_LOOP_ENABLE:     loop_enable_ff     <= pwdata[0];
            CSR_X_STEP:          x_step_ff          <= pwdata[Q16_W-1:0];
            CSR_Y_STEP:          y_step_ff          <= pwdata[Q16_W-1:0];
            CSR_OVERRIDE_ENABLE: override_enable_ff <= pwdata[0];
            CSR_OVERRIDE_HEIGHT: override_height_ff <= pwdata[Q16_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      frame_in       = frame_ff;
      acc_in         = acc_ff;
      wrap_in        = wrap_ff;
      rej_in         = rej_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      prod_x_in      = prod_x_ff;
      prod_y_in      = prod_y_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      div_req        = '0;
      req_stall      = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rej_in = 1'b0;
               if (req_payload.opcode == OP_SET_FRAME) begin
                  if (req_payload.frame_value > frame_count_ff) begin
                     rej_in = 1'b1;
                  end else begin
                     frame_in = req_payload.frame_value;
                  end
                  state_in = ST_SHEET_GO;
               end else begin
                  acc_in   = acc_ff + ACC_W'(req_payload.elapsed);
                  state_in = ST_TICK_GO;
               end
            end
         end
         ST_TICK_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {acc_ff, 1'b0};
            div_req.divisor  = period_eff;
            div_req.steps    = TICK_STEPS;
            state_in         = ST_TICK_WAIT;
         end
         ST_TICK_WAIT: begin
            if (div_rsp.done) begin
               acc_in   = ACC_W'(div_rsp.remainder);
               state_in = ST_SHEET_GO;
               if (div_rsp.quotient[ACC_W-1:0] != '0) begin
                  if (next_sum < DIVD_W'(frame_count_ff)) begin
                     frame_in = next_sum[FRAME_W-1:0];
                  end else if (frame_count_ff == '0) begin
                     frame_in = '0;
                  end else if (!loop_enable_ff) begin
                     frame_in = frame_count_ff - FRAME_W'(1);
                  end else begin
                     wrap_in  = next_sum;
                     state_in = ST_WRAP_GO;
                  end
               end
            end
         end
         ST_WRAP_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = wrap_ff;
            div_req.divisor  = DIVR_W'(frame_count_ff);
            div_req.steps    = WRAP_STEPS;
            state_in         = ST_WRAP_WAIT;
         end
         ST_WRAP_WAIT: begin
            if (div_rsp.done) begin
               frame_in = div_rsp.remainder[FRAME_W-1:0];
               state_in = ST_SHEET_GO;
            end
         end
         ST_SHEET_GO: begin
            // frame sits at the top so only its ten quotient bits are worked
            div_req.start    = 1'b1;
            div_req.dividend = {frame_ff, (DIVD_W-FRAME_W)'(0)};
            div_req.divisor  = DIVR_W'(fpr_eff);
            div_req.steps    = SHEET_STEPS;
            state_in         = ST_SHEET_WAIT;
         end
         ST_SHEET_WAIT: begin
            if (div_rsp.done) begin
               col_in   = div_rsp.remainder[FRAME_W-1:0];
               row_in   = div_rsp.quotient[FRAME_W-1:0];
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            prod_x_in = COORD_W'(x_step_ff) * COORD_W'(col_ff);
            prod_y_in = COORD_W'(y_step_ff) * COORD_W'(row_ff);
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_payload_in.frame    = frame_ff;
               rsp_payload_in.rejected = rej_ff;
               if (override_enable_ff) begin
                  rsp_payload_in.tex_x = '0;
                  rsp_payload_in.tex_y = COORD_W'(ONE_Q16 - height_eff);
                  rsp_payload_in.tex_w = ONE_Q16;
                  rsp_payload_in.tex_h = height_eff;
               end else begin
                  rsp_payload_in.tex_x = prod_x_ff;
                  rsp_payload_in.tex_y = prod_y_ff;
                  rsp_payload_in.tex_w = x_step_ff;
                  rsp_payload_in.tex_h = y_step_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_ff     <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wrap_ff        <= wrap_in;
      rej_ff         <= rej_in;
      col_ff         <= col_in;
      row_ff         <= row_in;
      prod_x_ff      <= prod_x_in;
      prod_y_ff      <= prod_y_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside output state");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_TICK_WAIT || state_ff == ST_WRAP_WAIT ||
                        state_ff == ST_SHEET_WAIT))
      else $error("divider finished outside a wait state");

   a_wrap_needed: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRAP_GO |-> frame_count_ff != '0 &&
                                 wrap_ff >= DIVD_W'(frame_count_ff))
      else $error("wrap division entered without overflow");

endmodule

>>> hdl/sfs_divider.sv
module sfs_divider (
   input  logic                clock,
   input  logic                reset,
   input  sfs_pkg::div_req_type div_req,
   output sfs_pkg::div_rsp_type div_rsp
);
   import sfs_pkg::*;

   logic [DIVD_W-1:0] work_ff, work_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] divisor_ff, divisor_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;

   logic [DIVR_W:0]   rem_shift;
   logic [DIVR_W+1:0] diff;
   logic              fits;

   assign rem_shift = {rem_ff, work_ff[DIVD_W-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, divisor_ff};
   assign fits      = ~diff[DIVR_W+1];

   always_comb begin
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         work_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         cnt_in     = div_req.steps;
      end else if (cnt_ff != '0) begin
         // one quotient bit per cycle, shifted in at the bottom
         work_in = {work_ff[DIVD_W-2:0], fits};
         rem_in  = fits ? diff[DIVR_W-1:0] : rem_shift[DIVR_W-1:0];
         cnt_in  = cnt_ff - STEP_W'(1);
         done_in = (cnt_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = work_ff;
   assign div_rsp.remainder = rem_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> cnt_ff == '0)
      else $error("divider started while busy");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(cnt_ff) == STEP_W'(1) && !$past(div_req.start))
      else $error("divider done without last step");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < divisor_ff)
      else $error("divider remainder not below divisor");

endmodule

>>> tb/sv/sprite_frame_sequencer_core_tb.sv
`timescale 1ns / 1ps

module sprite_frame_sequencer_core_tb;
   import sfs_pkg::*;

   localparam int          CYCLE_LIMIT = 800_000;
   localparam int          END_SETTLE  = 70;
   localparam int          HOLD_OFF    = 400;
   localparam logic [63:0] COORD_MAX   = 64'd134217727;
   localparam logic [63:0] ONE         = 64'(ONE_Q16);

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic [2:0]      csr;
      logic [31:0]     value;
      req_payload_type item;
      bit              typed;
      rsp_payload_type result;
   } plan_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            psel = 1'b0;
   logic            penable = 1'b0;
   logic            pwrite = 1'b0;
   logic [4:0]      paddr = '0;
   logic [31:0]     pwdata = '0;
   logic [31:0]     prdata;
   logic            pready;

   // register copies and sequencer state for the predictor
   logic [FRAME_W-1:0] cfg_count      = 10'd1;
   logic [FRAME_W-1:0] cfg_per_row    = 10'd1;
   logic [TICK_W-1:0]  cfg_period     = 20'd1;
   logic               cfg_loop       = 1'b1;
   logic [Q16_W-1:0]   cfg_x_step     = ONE_Q16;
   logic [Q16_W-1:0]   cfg_y_step     = ONE_Q16;
   logic               cfg_ovr_en     = 1'b0;
   logic [Q16_W-1:0]   cfg_ovr_height = '0;
   logic [FRAME_W-1:0] seq_frame      = '0;
   logic [ACC_W-1:0]   seq_ticks      = '0;

   rsp_payload_type pending_frames[$];
   plan_row_type    plan[$];
   rsp_payload_type rsp_want;
   int              mismatches = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              hold_requests = 0;
   int              hold_seen = 0;
   int              hold_left = 0;
   int              cycle_count;

   sprite_frame_sequencer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] sat_coord(input logic [63:0] v);
      return (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   function automatic rsp_payload_type animate_step(input req_payload_type it);
      rsp_payload_type r;
      logic [63:0]     period;
      logic [63:0]     periods;
      logic [63:0]     next;
      logic [63:0]     fpr;
      logic [63:0]     h;
      r = '0;
      if (it.opcode == OP_SET_FRAME) begin
         if (it.frame_value > cfg_count) r.rejected = 1'b1;
         else seq_frame = it.frame_value;
      end else begin
         period = (cfg_period == 0) ? 64'd1 : 64'(cfg_period);
         seq_ticks = seq_ticks + ACC_W'(it.elapsed);
         periods = 64'(seq_ticks) / period;
         if (periods != 0) begin
            next = 64'(seq_frame) + periods;
            if (next >= 64'(cfg_count)) begin
               if (cfg_count == 0) next = 64'd0;
               else if (cfg_loop) next = next % 64'(cfg_count);
               else next = 64'(cfg_count) - 64'd1;
            end
            seq_frame = next[FRAME_W-1:0];
            seq_ticks = ACC_W'(64'(seq_ticks) - periods * period);
         end
      end
      if (cfg_ovr_en) begin
         h = (64'(cfg_ovr_height) > ONE) ? ONE : 64'(cfg_ovr_height);
         r.tex_x = '0;
         r.tex_w = ONE_Q16;
         r.tex_h = h[Q16_W-1:0];
         r.tex_y = COORD_W'(ONE - h);
      end else begin
         fpr = (cfg_per_row == 0) ? 64'd1 : 64'(cfg_per_row);
         r.tex_w = cfg_x_step;
         r.tex_h = cfg_y_step;
         r.tex_x = COORD_W'(sat_coord(64'(cfg_x_step) * (64'(seq_frame) % fpr)));
         r.tex_y = COORD_W'(sat_coord(64'(cfg_y_step) * (64'(seq_frame) / fpr)));
      end
      r.frame = seq_frame;
      return r;
   endfunction

   function automatic void plan_csr(input logic [2:0] idx, input logic [31:0] v);
      plan_row_type row;
      row = '{kind: ROW_CSR, default: '0};
      row.csr = idx;
      row.value = v;
      plan.insert(plan.size(), row);
   endfunction

   function automatic void plan_item(input logic op, input int unsigned el,
                                     input int unsigned fv);
      plan_row_type row;
      row = '{kind: ROW_ITEM, default: '0};
      row.item.opcode = op;
      row.item.elapsed = el[TICK_W-1:0];
      row.item.frame_value = fv[FRAME_W-1:0];
      plan.insert(plan.size(), row);
   endfunction

   // item whose result is plain to see: frame, x, y, w, h, rejected
   function automatic void plan_known(input logic op, input int unsigned el,
                                      input int unsigned fv, input int unsigned fr,
                                      input int unsigned tx, input int unsigned ty,
                                      input int unsigned tw, input int unsigned th,
                                      input logic rej);
      int last;
      plan_item(op, el, fv);
      last = plan.size() - 1;
      plan[last].typed = 1'b1;
      plan[last].result.frame = fr[FRAME_W-1:0];
      plan[last].result.tex_x = tx[COORD_W-1:0];
      plan[last].result.tex_y = ty[COORD_W-1:0];
      plan[last].result.tex_w = tw[Q16_W-1:0];
      plan[last].result.tex_h = th[Q16_W-1:0];
      plan[last].result.rejected = rej;
   endfunction

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         CSR_FRAME_COUNT:     cfg_count = v[FRAME_W-1:0];
         CSR_FRAMES_PER_ROW:  cfg_per_row = v[FRAME_W-1:0];
         CSR_FRAME_PERIOD:    cfg_period = v[TICK_W-1:0];
         CSR_LOOP_ENABLE:     cfg_loop = v[0];
         CSR_X_STEP:          cfg_x_step = v[Q16_W-1:0];
         CSR_Y_STEP:          cfg_y_step = v[Q16_W-1:0];
         CSR_OVERRIDE_ENABLE: cfg_ovr_en = v[0];
         CSR_OVERRIDE_HEIGHT: cfg_ovr_height = v[Q16_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_item(input req_payload_type it, input bit typed,
                            input rsp_payload_type known);
      rsp_payload_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = animate_step(it);
      pending_frames.insert(pending_frames.size(), typed ? known : predicted);
   endtask

   // drop valid and hold until every outstanding result is back
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_frames.size() != 0) @(posedge clock);
   endtask

   task automatic shuffle_settings();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 1023;
         2: v = $urandom_range(0, 1023);
         default: v = $urandom_range(1, 16);
      endcase
      write_csr(CSR_FRAME_COUNT, v);
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 1023;
         2: v = $urandom_range(0, 1023);
         default: v = $urandom_range(1, 6);
      endcase
      write_csr(CSR_FRAMES_PER_ROW, v);
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 1048575;
         2: v = $urandom_range(0, 1048575);
         default: v = $urandom_range(1, 20);
      endcase
      write_csr(CSR_FRAME_PERIOD, v);
      write_csr(CSR_LOOP_ENABLE, $urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0: v = 0;
         1: v = 131071;
         2: v = 65536;
         default: v = $urandom_range(0, 131071);
      endcase
      write_csr(CSR_X_STEP, v);
      case ($urandom_range(0, 5))
         0: v = 0;
         1: v = 131071;
         2: v = 65536;
         default: v = $urandom_range(0, 131071);
      endcase
      write_csr(CSR_Y_STEP, v);
      write_csr(CSR_OVERRIDE_ENABLE, 32'($urandom_range(0, 3) == 0));
      write_csr(CSR_OVERRIDE_HEIGHT, $urandom_range(0, 131071));
   endtask

   task automatic send_random_item();
      req_payload_type it;
      rsp_payload_type none;
      logic [63:0]     span;
      none = '0;
      it.elapsed = TICK_W'($urandom_range(0, 1048575));
      it.frame_value = FRAME_W'($urandom_range(0, 1023));
      if ($urandom_range(0, 9) < 7) begin
         it.opcode = OP_ADVANCE;
         // mostly a few periods' worth, now and then anything
         span = 3 * ((cfg_period == 0) ? 64'd1 : 64'(cfg_period));
         if (span > 1048575) span = 1048575;
         if ($urandom_range(0, 7) != 0)
            it.elapsed = TICK_W'($urandom_range(0, span[31:0]));
      end else begin
         it.opcode = OP_SET_FRAME;
         span = 64'(cfg_count) + 2;
         if (span > 1023) span = 1023;
         if ($urandom_range(0, 3) != 0)
            it.frame_value = FRAME_W'($urandom_range(0, span[31:0]));
      end
      send_item(it, 1'b0, none);
   endtask

   task automatic flag_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
      end
   endtask

   // result checking and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t unexpected result, frame %0d", $realtime, rsp_payload.frame);
         end else begin
            rsp_want = pending_frames.pop_front();
            flag_field("frame", 64'(rsp_want.frame), 64'(rsp_payload.frame));
            flag_field("tex_x", 64'(rsp_want.tex_x), 64'(rsp_payload.tex_x));
            flag_field("tex_y", 64'(rsp_want.tex_y), 64'(rsp_payload.tex_y));
            flag_field("tex_w", 64'(rsp_want.tex_w), 64'(rsp_payload.tex_w));
            flag_field("tex_h", 64'(rsp_want.tex_h), 64'(rsp_payload.tex_h));
            flag_field("rejected", 64'(rsp_want.rejected), 64'(rsp_payload.rejected));
         end
      end
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HOLD_OFF;
      end
      rsp_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);
      if (hold_left > 0) hold_left--;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      // reset register values
      plan_known(OP_ADVANCE, 0, 0, 0, 0, 0, ONE_Q16, ONE_Q16, 1'b0);
      plan_known(OP_SET_FRAME, 0, 1, 1, 0, ONE_Q16, ONE_Q16, ONE_Q16, 1'b0);
      plan_known(OP_SET_FRAME, 0, 2, 1, 0, ONE_Q16, ONE_Q16, ONE_Q16, 1'b1);
      plan_known(OP_SET_FRAME, 1048575, 1023, 1, 0, ONE_Q16, ONE_Q16, ONE_Q16, 1'b1);
      // frame past the count, no whole period: hold it
      plan_known(OP_ADVANCE, 0, 1023, 1, 0, ONE_Q16, ONE_Q16, ONE_Q16, 1'b0);
      plan_known(OP_ADVANCE, 1, 0, 0, 0, 0, ONE_Q16, ONE_Q16, 1'b0);
      plan_known(OP_ADVANCE, 1048575, 0, 0, 0, 0, ONE_Q16, ONE_Q16, 1'b0);
      // zero count and zero period
      plan_csr(CSR_FRAME_COUNT, 0);
      plan_csr(CSR_FRAME_PERIOD, 0);
      plan_item(OP_ADVANCE, 5, 0);
      plan_known(OP_SET_FRAME, 0, 1, 0, 0, 0, ONE_Q16, ONE_Q16, 1'b1);
      plan_item(OP_SET_FRAME, 0, 0);
      // widest settings, clamp at the last frame
      plan_csr(CSR_FRAME_COUNT, 1023);
      plan_csr(CSR_FRAMES_PER_ROW, 0);
      plan_csr(CSR_FRAME_PERIOD, 1048575);
      plan_csr(CSR_LOOP_ENABLE, 0);
      plan_csr(CSR_X_STEP, 131071);
      plan_csr(CSR_Y_STEP, 131071);
      plan_item(OP_SET_FRAME, 0, 1023);
      plan_item(OP_ADVANCE, 0, 0);
      plan_item(OP_ADVANCE, 1048575, 0);
      plan_item(OP_ADVANCE, 1048574, 0);
      plan_item(OP_ADVANCE, 1048575, 0);
      // wrap from beyond the count, height override incl. oversized
      plan_csr(CSR_LOOP_ENABLE, 1);
      plan_csr(CSR_FRAMES_PER_ROW, 1023);
      plan_csr(CSR_FRAME_COUNT, 5);
      plan_csr(CSR_FRAME_PERIOD, 3);
      plan_csr(CSR_OVERRIDE_ENABLE, 1);
      plan_csr(CSR_OVERRIDE_HEIGHT, 131071);
      plan_item(OP_ADVANCE, 7, 0);
      plan_item(OP_SET_FRAME, 0, 3);
      plan_csr(CSR_OVERRIDE_HEIGHT, 0);
      plan_item(OP_ADVANCE, 2, 0);
      plan_csr(CSR_OVERRIDE_HEIGHT, 65536);
      plan_item(OP_ADVANCE, 0, 0);
      plan_csr(CSR_OVERRIDE_HEIGHT, 32768);
      plan_csr(CSR_OVERRIDE_ENABLE, 0);
      plan_csr(CSR_X_STEP, 0);
      plan_csr(CSR_Y_STEP, 0);
      plan_csr(CSR_FRAMES_PER_ROW, 2);
      plan_item(OP_SET_FRAME, 0, 5);
      plan_item(OP_ADVANCE, 4, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle_block();
            write_csr(plan[i].csr, plan[i].value);
         end else begin
            send_item(plan[i].item, plan[i].typed, plan[i].result);
         end
      end

      for (int phase = 0; phase < 8; phase++) begin
         settle_block();
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 48; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 48; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
         endcase
         shuffle_settings();
         for (int n = 0; n < 100; n++) begin
            // long receiver hold-off while items keep coming
            if (phase == 0 && n == 20) hold_requests++;
            send_random_item();
         end
      end

      settle_block();
      repeat (END_SETTLE) @(posedge clock);
      if (mismatches == 0 && pending_frames.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/sfs_pkg.sv
hdl/sfs_divider.sv
hdl/sprite_frame_sequencer_core.sv
tb/sv/sprite_frame_sequencer_core_tb.sv
